// ----- hdl/mfs_pkg.sv -----
// Shared types, state codes and helper functions for the feedback scheduler.
// No dependencies; used by every module of the block.
package mfs_pkg;

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_DECIDE,
        ST_REQUEUE,
        ST_DISPATCH,
        ST_RUN
    } mfs_state_t;

    typedef struct packed {
        logic       push;
        logic [7:0] id;
        logic [9:0] service;
        logic       pending;
    } mfs_item_t;

    typedef struct packed {
        logic       fresh;
        logic [9:0] service;
        logic [7:0] id;
    } mfs_entry_t;

    localparam logic [1:0] CFG_SLICE_DOUBLING = 2'd0;
    localparam logic [1:0] CFG_SWITCH_COST    = 2'd1;

    localparam logic [31:0] TICK_STEP = 32'd16;

    function automatic logic [3:0] slice_len(input logic dbl, input logic [2:0] lvl);
        logic [3:0] len;
        begin
            if (!dbl)
            begin
                len = 4'd1;
            end
            else
            begin
                case (lvl)
                    3'd0:    len = 4'd1;
                    3'd1:    len = 4'd2;
                    3'd2:    len = 4'd4;
                    default: len = 4'd8;
                endcase
            end
            return len;
        end
    endfunction

endpackage

// ----- hdl/mfs_front.sv -----
// Front end: accepts tick transactions, classifies the arrival and buffers
// them in a two-entry queue for the back end. Depends on mfs_pkg.
module mfs_front
    import mfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        arrive_valid,
    input  logic [7:0]  arrive_id,
    input  logic [9:0]  arrive_service,
    input  logic        more_pending,
    output logic        item_valid,
    output mfs_item_t   item,
    input  logic        item_pop
);

    mfs_item_t  buf_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       take;
    logic       give;
    mfs_item_t  cls;

    assign in_stall   = (cnt_reg == 2'd2);
    assign take       = in_valid && !in_stall;
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = buf_reg[rd_ptr_reg];
    assign give       = item_pop && item_valid;

    always_comb
    begin
        cls.push    = arrive_valid && (arrive_id != 8'd0);
        cls.id      = arrive_id;
        cls.service = (arrive_service == 10'd0) ? 10'd1 : arrive_service;
        cls.pending = more_pending;
    end

    always_comb
    begin
        wr_ptr_next = take ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = give ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + (take ? 2'd1 : 2'd0) - (give ? 2'd1 : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            buf_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ----- hdl/mfs_back.sv -----
// Back end: per-level job queues in one memory, the running job and the
// tick sequencer with the result register. Depends on mfs_pkg.
module mfs_back
    import mfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int LEVELS      = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        slice_doubling,
    input  logic [7:0]  switch_cost,
    input  logic        item_valid,
    input  mfs_item_t   item,
    output logic        item_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  run_id,
    output logic        all_done,
    output logic        first_run,
    output logic        finished_valid,
    output logic [7:0]  finished_id,
    output logic        switched,
    output logic [31:0] now_time
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = PW + 2;
    localparam int LW = $clog2(LEVELS);
    localparam int AW = $clog2(LEVELS * QUEUE_DEPTH);
    localparam logic [CW-1:0] QD_CNT  = CW'(QUEUE_DEPTH);
    localparam logic [SW-1:0] QD_SUM  = SW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] QD_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [AW-1:0] QD_ADDR = AW'(QUEUE_DEPTH);
    localparam logic [LW-1:0] LVL_LAST = LW'(LEVELS - 1);

    mfs_entry_t mem [LEVELS * QUEUE_DEPTH];
    mfs_entry_t rd_data_reg;

    mfs_state_t state_reg, state_next;
    logic [CW-1:0] count_reg [LEVELS];
    logic [CW-1:0] count_next [LEVELS];
    logic [PW-1:0] head_reg [LEVELS];
    logic [PW-1:0] head_next [LEVELS];
    logic [7:0]  cur_id_reg, cur_id_next;
    logic [9:0]  cur_rem_reg, cur_rem_next;
    logic        cur_fresh_reg, cur_fresh_next;
    logic [3:0]  slice_reg, slice_next;
    logic [LW-1:0] cur_lvl_reg, cur_lvl_next;
    logic [31:0] time_reg, time_next;
    logic        pending_reg, pending_next;
    logic        fin_v_reg, fin_v_next;
    logic [7:0]  fin_id_reg, fin_id_next;
    logic        sw_reg, sw_next;
    logic [LW-1:0] disp_lvl_reg, disp_lvl_next;
    logic        chg_all_reg, chg_all_next;
    logic        chg_cmp_reg, chg_cmp_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  o_run_reg, o_run_next;
    logic        o_done_reg, o_done_next;
    logic        o_first_reg, o_first_next;
    logic        o_fin_v_reg, o_fin_v_next;
    logic [7:0]  o_fin_id_reg, o_fin_id_next;
    logic        o_sw_reg, o_sw_next;
    logic [31:0] o_time_reg, o_time_next;

    logic          hl_found;
    logic [LW-1:0] hl_idx;
    logic          any_queued;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    mfs_entry_t    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [LW-1:0] tgt;
    logic [SW-1:0] tail_sum;
    logic [PW-1:0] tail;
    logic          out_free;
    logic          charge;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        hl_found = 1'b0;
        hl_idx   = '0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (count_reg[l] != '0)
            begin
                hl_found = 1'b1;
                hl_idx   = LW'(l);
            end
        end
    end

    assign any_queued = hl_found;

    always_comb
    begin
        tgt = cur_lvl_reg;
        if (cur_lvl_reg != LVL_LAST && hl_found)
        begin
            tgt = cur_lvl_reg + LW'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_WAIT:
            begin
                if (item_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (cur_id_reg == 8'd0 || cur_rem_reg == 10'd0)
                begin
                    state_next = hl_found ? ST_DISPATCH : ST_RUN;
                end
                else if (slice_reg == 4'd0 && count_reg[tgt] < QD_CNT)
                begin
                    state_next = ST_REQUEUE;
                end
                else
                begin
                    state_next = ST_RUN;
                end
            end
            ST_REQUEUE:  state_next = ST_DISPATCH;
            ST_DISPATCH: state_next = ST_RUN;
            ST_RUN:
            begin
                if (out_free)
                begin
                    state_next = ST_WAIT;
                end
            end
            default:     state_next = ST_WAIT;
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        head_next      = head_reg;
        cur_id_next    = cur_id_reg;
        cur_rem_next   = cur_rem_reg;
        cur_fresh_next = cur_fresh_reg;
        slice_next     = slice_reg;
        cur_lvl_next   = cur_lvl_reg;
        time_next      = time_reg;
        pending_next   = pending_reg;
        fin_v_next     = fin_v_reg;
        fin_id_next    = fin_id_reg;
        sw_next        = sw_reg;
        disp_lvl_next  = disp_lvl_reg;
        chg_all_next   = chg_all_reg;
        chg_cmp_next   = chg_cmp_reg;
        out_valid_next = out_valid_reg && out_stall;
        o_run_next     = o_run_reg;
        o_done_next    = o_done_reg;
        o_first_next   = o_first_reg;
        o_fin_v_next   = o_fin_v_reg;
        o_fin_id_next  = o_fin_id_reg;
        o_sw_next      = o_sw_reg;
        o_time_next    = o_time_reg;
        item_pop       = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        tail_sum       = '0;
        tail           = '0;
        charge         = 1'b0;
        case (state_reg)
            ST_WAIT:
            begin
                if (item_valid)
                begin
                    item_pop     = 1'b1;
                    pending_next = item.pending;
                    fin_v_next   = 1'b0;
                    fin_id_next  = 8'd0;
                    sw_next      = 1'b0;
                    tail_sum     = SW'(head_reg[0]) + SW'(count_reg[0]);
                    if (tail_sum >= QD_SUM)
                    begin
                        tail_sum = tail_sum - QD_SUM;
                    end
                    tail = tail_sum[PW-1:0];
                    if (item.push && count_reg[0] < QD_CNT)
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = AW'(tail);
                        wr_data.fresh = 1'b1;
                        wr_data.service = item.service;
                        wr_data.id    = item.id;
                        count_next[0] = count_reg[0] + CW'(1);
                    end
                end
            end
            ST_DECIDE:
            begin
                rd_addr = AW'(hl_idx) * QD_ADDR + AW'(head_reg[hl_idx]);
                disp_lvl_next = hl_idx;
                if (cur_id_reg == 8'd0)
                begin
                    rd_en        = hl_found;
                    chg_all_next = 1'b0;
                    chg_cmp_next = 1'b0;
                end
                else if (cur_rem_reg == 10'd0)
                begin
                    fin_v_next   = 1'b1;
                    fin_id_next  = cur_id_reg;
                    rd_en        = hl_found;
                    chg_all_next = 1'b1;
                    chg_cmp_next = 1'b0;
                    if (!hl_found)
                    begin
                        cur_id_next    = 8'd0;
                        cur_fresh_next = 1'b0;
                        slice_next     = 4'd0;
                    end
                end
                else if (slice_reg == 4'd0)
                begin
                    if (count_reg[tgt] < QD_CNT)
                    begin
                        tail_sum = SW'(head_reg[tgt]) + SW'(count_reg[tgt]);
                        if (tail_sum >= QD_SUM)
                        begin
                            tail_sum = tail_sum - QD_SUM;
                        end
                        tail            = tail_sum[PW-1:0];
                        wr_en           = 1'b1;
                        wr_addr         = AW'(tgt) * QD_ADDR + AW'(tail);
                        wr_data.fresh   = cur_fresh_reg;
                        wr_data.service = cur_rem_reg;
                        wr_data.id      = cur_id_reg;
                        count_next[tgt] = count_reg[tgt] + CW'(1);
                    end
                    else
                    begin
                        slice_next = slice_len(slice_doubling, 3'(cur_lvl_reg));
                    end
                end
            end
            ST_REQUEUE:
            begin
                rd_en         = 1'b1;
                rd_addr       = AW'(hl_idx) * QD_ADDR + AW'(head_reg[hl_idx]);
                disp_lvl_next = hl_idx;
                chg_all_next  = 1'b0;
                chg_cmp_next  = 1'b1;
            end
            ST_DISPATCH:
            begin
                charge = chg_all_reg || (chg_cmp_reg && rd_data_reg.id != cur_id_reg);
                if (charge)
                begin
                    time_next = time_reg + {24'd0, switch_cost};
                    sw_next   = 1'b1;
                end
                cur_id_next    = rd_data_reg.id;
                cur_rem_next   = rd_data_reg.service;
                cur_fresh_next = rd_data_reg.fresh;
                cur_lvl_next   = disp_lvl_reg;
                slice_next     = slice_len(slice_doubling, 3'(disp_lvl_reg));
                count_next[disp_lvl_reg] = count_reg[disp_lvl_reg] - CW'(1);
                head_next[disp_lvl_reg]  = (head_reg[disp_lvl_reg] == QD_LAST) ? '0 :
                                           head_reg[disp_lvl_reg] + PW'(1);
            end
            ST_RUN:
            begin
                if (out_free)
                begin
                    o_run_next   = cur_id_reg;
                    o_first_next = (cur_id_reg != 8'd0) && cur_fresh_reg;
                    if (cur_id_reg != 8'd0)
                    begin
                        cur_fresh_next = 1'b0;
                        if (cur_rem_reg != 10'd0)
                        begin
                            cur_rem_next = cur_rem_reg - 10'd1;
                        end
                        if (slice_reg != 4'd0)
                        begin
                            slice_next = slice_reg - 4'd1;
                        end
                    end
                    time_next      = time_reg + TICK_STEP;
                    o_time_next    = time_reg + TICK_STEP;
                    o_done_next    = (cur_id_reg == 8'd0) && !any_queued && !pending_reg;
                    o_fin_v_next   = fin_v_reg;
                    o_fin_id_next  = fin_id_reg;
                    o_sw_next      = sw_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WAIT;
            for (int l = 0; l < LEVELS; l++)
            begin
                count_reg[l] <= '0;
                head_reg[l]  <= '0;
            end
            cur_id_reg    <= 8'd0;
            cur_rem_reg   <= 10'd0;
            cur_fresh_reg <= 1'b0;
            slice_reg     <= 4'd0;
            cur_lvl_reg   <= '0;
            time_reg      <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            cur_id_reg    <= cur_id_next;
            cur_rem_reg   <= cur_rem_next;
            cur_fresh_reg <= cur_fresh_next;
            slice_reg     <= slice_next;
            cur_lvl_reg   <= cur_lvl_next;
            time_reg      <= time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pending_reg  <= pending_next;
        fin_v_reg    <= fin_v_next;
        fin_id_reg   <= fin_id_next;
        sw_reg       <= sw_next;
        disp_lvl_reg <= disp_lvl_next;
        chg_all_reg  <= chg_all_next;
        chg_cmp_reg  <= chg_cmp_next;
        o_run_reg    <= o_run_next;
        o_done_reg   <= o_done_next;
        o_first_reg  <= o_first_next;
        o_fin_v_reg  <= o_fin_v_next;
        o_fin_id_reg <= o_fin_id_next;
        o_sw_reg     <= o_sw_next;
        o_time_reg   <= o_time_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid      = out_valid_reg;
    assign run_id         = o_run_reg;
    assign all_done       = o_done_reg;
    assign first_run      = o_first_reg;
    assign finished_valid = o_fin_v_reg;
    assign finished_id    = o_fin_id_reg;
    assign switched       = o_sw_reg;
    assign now_time       = o_time_reg;

    // A dispatched level must still hold at least one job.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DISPATCH |-> count_reg[disp_lvl_reg] != '0)
        else $error("dispatch from an empty level");

    // A job that is about to run always has slice time left.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && cur_id_reg != 8'd0) |-> slice_reg != 4'd0)
        else $error("running job without slice");

    // Neither the first nor the last level queue ever holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[0] <= QD_CNT && count_reg[LVL_LAST] <= QD_CNT)
        else $error("level queue overflow");

    // A result is produced only on leaving the run step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!$past(out_valid_reg) && out_valid_reg) |-> $past(state_reg) == ST_RUN)
        else $error("result outside run step");

endmodule

// ----- hdl/multilevel_feedback_scheduler.sv -----
// Top level of the four-level feedback scheduler: configuration registers,
// front end and back end. Depends on mfs_pkg, mfs_front and mfs_back.
// Each input transaction is one time tick and yields one result transaction.
// In the back end a tick passes through these steps in order: take the tick and
// enqueue its arrival, decide, requeue an expired job if needed, take the next
// job from the queue memory if one is dispatched, then run. All levels share one
// queue memory. The front buffers two ticks so the input side keeps moving while
// the back end works. Configuration writes are always accepted and take effect
// as soon as they are registered, also within a tick in progress.
module multilevel_feedback_scheduler
    import mfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int LEVELS      = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        arrive_valid,
    input  logic [7:0]  arrive_id,
    input  logic [9:0]  arrive_service,
    input  logic        more_pending,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  run_id,
    output logic        all_done,
    output logic        first_run,
    output logic        finished_valid,
    output logic [7:0]  finished_id,
    output logic        switched,
    output logic [31:0] now_time,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic       slice_doubling_reg;
    logic [7:0] switch_cost_reg;
    logic       item_valid;
    mfs_item_t  item;
    logic       item_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_doubling_reg <= 1'b1;
            switch_cost_reg    <= 8'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SLICE_DOUBLING: slice_doubling_reg <= cfg_data[0];
                CFG_SWITCH_COST:    switch_cost_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    mfs_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .arrive_valid   (arrive_valid),
        .arrive_id      (arrive_id),
        .arrive_service (arrive_service),
        .more_pending   (more_pending),
        .item_valid     (item_valid),
        .item           (item),
        .item_pop       (item_pop)
    );

    mfs_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LEVELS      (LEVELS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .slice_doubling (slice_doubling_reg),
        .switch_cost    (switch_cost_reg),
        .item_valid     (item_valid),
        .item           (item),
        .item_pop       (item_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .run_id         (run_id),
        .all_done       (all_done),
        .first_run      (first_run),
        .finished_valid (finished_valid),
        .finished_id    (finished_id),
        .switched       (switched),
        .now_time       (now_time)
    );

endmodule
